@@ sv/tcc_pkg.sv @@
// Shared types and constants for the text cell console with cursor and scroll.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package tcc_pkg;

	// Field widths of the item, the result and the configuration port
	localparam int CODE_W     = 21;
	localparam int COLOR_W    = 24;
	localparam int COL_W      = 7;
	localparam int LINE_W     = 6;
	localparam int CFGCOL_W   = 8;
	localparam int CFGROW_W   = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Default grid size
	localparam int MAX_COLUMNS_DEF = 128;
	localparam int MAX_ROWS_DEF    = 64;

	// Character and color constants
	localparam logic [CODE_W-1:0]  SPACE_CODE    = 21'd32;
	localparam logic [CODE_W-1:0]  NEWLINE_CODE  = 21'd10;
	localparam logic [COLOR_W-1:0] DEFAULT_FRONT = 24'haaaaaa;
	localparam logic [COLOR_W-1:0] DEFAULT_BACK  = 24'h000000;

	// Register reset values
	localparam logic [CFGCOL_W-1:0] COLS_RESET = 8'd128;
	localparam logic [CFGROW_W-1:0] ROWS_RESET = 7'd48;
	localparam logic [COLOR_W-1:0]  TEXT_RESET = 24'haaaaaa;
	localparam logic [COLOR_W-1:0]  BACK_RESET = 24'h000000;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLUMNS = 2'd0,
		CFG_ROWS    = 2'd1,
		CFG_TEXT    = 2'd2,
		CFG_BACK    = 2'd3
	} cfg_idx_t;

	// Request classes decided by the front part
	typedef enum logic [1:0] {
		K_PUT      = 2'd0,
		K_NEWLINE  = 2'd1,
		K_READ     = 2'd2,
		K_READ_OUT = 2'd3
	} kind_t;

	typedef struct packed {
		logic [CFGCOL_W-1:0] cols;
		logic [CFGROW_W-1:0] rows;
		logic [COLOR_W-1:0]  text;
		logic [COLOR_W-1:0]  back;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [CODE_W-1:0]  code;
		logic [COL_W-1:0]   read_col;
		logic [LINE_W-1:0]  read_line;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0]   cursor_col;
		logic [LINE_W-1:0]  cursor_line;
		logic               did_scroll;
		logic [CODE_W-1:0]  cell_code;
		logic [COLOR_W-1:0] cell_front;
		logic [COLOR_W-1:0] cell_back;
		logic               cell_needs_draw;
	} res_t;

endpackage

`default_nettype wire

@@ sv/tcc_in_if.sv @@
// Request channel of the text console: valid/ready plus the request fields.
// Depends on tcc_pkg for field widths.
`default_nettype none

interface tcc_in_if;
	import tcc_pkg::*;

	logic              valid;
	logic              ready;
	logic              op;
	logic [CODE_W-1:0] char_code;
	logic [COL_W-1:0]  read_col;
	logic [LINE_W-1:0] read_line;

	modport source (output valid, op, char_code, read_col, read_line, input ready);
	modport sink   (input valid, op, char_code, read_col, read_line, output ready);
endinterface

`default_nettype wire

@@ sv/tcc_out_if.sv @@
// Result channel of the text console: valid/ready plus the result fields.
// Depends on tcc_pkg for field widths.
`default_nettype none

interface tcc_out_if;
	import tcc_pkg::*;

	logic               valid;
	logic               ready;
	logic [COL_W-1:0]   cursor_col;
	logic [LINE_W-1:0]  cursor_line;
	logic               did_scroll;
	logic [CODE_W-1:0]  cell_code;
	logic [COLOR_W-1:0] cell_front;
	logic [COLOR_W-1:0] cell_back;
	logic               cell_needs_draw;

	modport source (output valid, cursor_col, cursor_line, did_scroll, cell_code,
		cell_front, cell_back, cell_needs_draw, input ready);
	modport sink   (input valid, cursor_col, cursor_line, did_scroll, cell_code,
		cell_front, cell_back, cell_needs_draw, output ready);
endinterface

`default_nettype wire

@@ sv/tcc_front.sv @@
// Front part: takes requests, classifies them and registers the command.
// Depends on tcc_pkg and tcc_in_if.
`default_nettype none

module tcc_front #(
	parameter int MAX_COLUMNS = tcc_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tcc_pkg::MAX_ROWS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	tcc_in_if.sink          item,
	output logic            push_valid,
	input  logic            push_ready,
	output tcc_pkg::cmd_t   push_cmd
);
	import tcc_pkg::*;

	logic  valid_s1;
	cmd_t  cmd_s1;
	cmd_t  cmd_cls;
	logic  in_grid;
	logic  take;

	// One register stage; it frees up whenever the queue takes its entry
	assign item.ready = !valid_s1 || push_ready;
	assign take       = item.valid && item.ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	// Classify the request
	always_comb begin
		in_grid = (int'(item.read_col) < MAX_COLUMNS) && (int'(item.read_line) < MAX_ROWS);
		cmd_cls.code      = item.char_code;
		cmd_cls.read_col  = item.read_col;
		cmd_cls.read_line = item.read_line;
		if (item.op) begin
			cmd_cls.kind = in_grid ? K_READ : K_READ_OUT;
		end else begin
			cmd_cls.kind = (item.char_code == NEWLINE_CODE) ? K_NEWLINE : K_PUT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_cls;
		end
	end

endmodule

`default_nettype wire

@@ sv/tcc_queue.sv @@
// Two-entry command queue between the front and the back part.
// Depends on tcc_pkg for the command type.
`default_nettype none

module tcc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  tcc_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output tcc_pkg::cmd_t pop_cmd
);
	import tcc_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

@@ sv/tcc_back.sv @@
// Back part: cell stores, dirty marks, cursor, scroll sequencer, result register.
// Depends on tcc_pkg and tcc_out_if.
`default_nettype none

module tcc_back #(
	parameter int MAX_COLUMNS = tcc_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tcc_pkg::MAX_ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tcc_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tcc_pkg::cmd_t cmd,
	tcc_out_if.source     result
);
	import tcc_pkg::*;

	localparam int CW    = $clog2(MAX_COLUMNS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int AW    = CW + RW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_UPD   = 4'b0100,
		ST_SCRL  = 4'b1000
	} st_t;

	// Stores: address is {stored row, column}
	logic [CODE_W-1:0]    code_mem  [DEPTH];
	logic [2*COLOR_W-1:0] color_mem [DEPTH];
	logic [MAX_COLUMNS-1:0] dirty_mem [MAX_ROWS];

	st_t                  st_q;
	logic [AW-1:0]        clr_q;
	logic [CW-1:0]        cur_col_q;
	logic [RW-1:0]        cur_row_q;
	logic [RW-1:0]        top_q;
	logic [MAX_ROWS-1:0]  flag_q;
	kind_t                kind_q;
	logic [CODE_W-1:0]    code_q;
	logic [CW-1:0]        col_q;
	logic [RW-1:0]        prow_q;
	logic [CW-1:0]        scol_q;
	logic [RW-1:0]        srow_q;
	logic [CODE_W-1:0]    code_rd_q;
	logic [2*COLOR_W-1:0] color_rd_q;
	logic [MAX_COLUMNS-1:0] dirty_rd_q;
	logic                 out_valid_q;
	res_t                 res_q;

	logic [CW:0]          ecols;
	logic [CW:0]          ecols_m1;
	logic [RW:0]          erows;
	logic [RW:0]          erows_m1;
	logic                 start;
	logic                 start_put;
	logic [CW-1:0]        ccol;
	logic [RW-1:0]        crow;
	logic [CW-1:0]        rd_col;
	logic [RW-1:0]        rd_row;
	logic [MAX_COLUMNS-1:0] row_bits;
	logic [MAX_COLUMNS-1:0] row_new;
	logic                 wrap;
	logic                 adv_row;
	logic [RW:0]          nrow;
	logic                 scroll;
	logic [CW-1:0]        col_next;
	logic [RW-1:0]        row_next;
	logic [RW-1:0]        new_top;
	logic                 scol_last;
	logic                 load;
	res_t                 res_d;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [CODE_W-1:0]    wr_code;
	logic [2*COLOR_W-1:0] wr_color;

	// Stored row of a screen row: (r + t) mod MAX_ROWS with both below MAX_ROWS
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r, input logic [RW-1:0] t);
		logic [RW:0] s;
		s = {1'b0, r} + {1'b0, t};
		if (s >= (RW+1)'(MAX_ROWS)) begin
			s = s - (RW+1)'(MAX_ROWS);
		end
		return s[RW-1:0];
	endfunction

	// Effective screen size from the registers
	always_comb begin
		if (cfg.cols == '0) begin
			ecols = (CW+1)'(1);
		end else if (int'(cfg.cols) > MAX_COLUMNS) begin
			ecols = (CW+1)'(MAX_COLUMNS);
		end else begin
			ecols = (CW+1)'(cfg.cols);
		end
		if (cfg.rows == '0) begin
			erows = (RW+1)'(1);
		end else if (int'(cfg.rows) > MAX_ROWS) begin
			erows = (RW+1)'(MAX_ROWS);
		end else begin
			erows = (RW+1)'(cfg.rows);
		end
		ecols_m1 = ecols - (CW+1)'(1);
		erows_m1 = erows - (RW+1)'(1);
	end

	// Start: one command at a time, only when the result register will be free
	assign start     = (st_q == ST_IDLE) && cmd_valid && (!out_valid_q || result.ready);
	assign cmd_ready = start;
	assign start_put = (cmd.kind == K_PUT) || (cmd.kind == K_NEWLINE);

	// Cursor clamp and read address for the head command
	always_comb begin
		ccol = ({1'b0, cur_col_q} >= ecols) ? ecols_m1[CW-1:0] : cur_col_q;
		crow = ({1'b0, cur_row_q} >= erows) ? erows_m1[RW-1:0] : cur_row_q;
		rd_col = start_put ? ccol : CW'(cmd.read_col);
		rd_row = phys_row(start_put ? crow : RW'(cmd.read_line), top_q);
	end

	// Update step: dirty row, cursor move, scroll decision
	always_comb begin
		row_bits = flag_q[prow_q] ? '1 : dirty_rd_q;
		row_new = row_bits;
		row_new[col_q] = (kind_q != K_READ);
		wrap    = ({1'b0, col_q} + (CW+1)'(1)) >= ecols;
		adv_row = (kind_q == K_NEWLINE) || ((kind_q == K_PUT) && wrap);
		nrow    = {1'b0, cur_row_q} + (RW+1)'(1);
		scroll  = adv_row && (nrow >= erows);
		col_next = cur_col_q;
		if (kind_q == K_NEWLINE || (kind_q == K_PUT && wrap)) begin
			col_next = '0;
		end else if (kind_q == K_PUT) begin
			col_next = col_q + CW'(1);
		end
		row_next = adv_row ? nrow[RW-1:0] : cur_row_q;
		new_top  = phys_row(RW'(1), top_q);
	end

	// Result of a command that ends in the update step, or of a scroll at the end of its sweep
	always_comb begin
		res_d = '0;
		res_d.cursor_col  = COL_W'(col_next);
		res_d.cursor_line = LINE_W'(row_next);
		if (kind_q == K_READ) begin
			res_d.cell_code       = code_rd_q;
			res_d.cell_front      = color_rd_q[2*COLOR_W-1:COLOR_W];
			res_d.cell_back       = color_rd_q[COLOR_W-1:0];
			res_d.cell_needs_draw = row_bits[col_q];
		end
		if (st_q == ST_SCRL) begin
			res_d = '0;
			res_d.cursor_line = LINE_W'(erows_m1);
			res_d.did_scroll  = 1'b1;
		end
	end

	assign scol_last = (scol_q == ecols_m1[CW-1:0]);
	assign load = ((st_q == ST_UPD) && !scroll) || ((st_q == ST_SCRL) && scol_last);

	// Cell store write port
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = {prow_q, col_q};
		wr_code  = SPACE_CODE;
		wr_color = {DEFAULT_FRONT, DEFAULT_BACK};
		unique case (st_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			ST_UPD: begin
				wr_en    = (kind_q == K_PUT);
				wr_code  = code_q;
				wr_color = {cfg.text, cfg.back};
			end
			ST_SCRL: begin
				wr_en   = 1'b1;
				wr_addr = {srow_q, scol_q};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Sequencer, cursor and dirty row flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_q     <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
			top_q     <= '0;
			flag_q    <= '1;
			scol_q    <= '0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						st_q <= ST_UPD;
						if (start_put) begin
							cur_col_q <= ccol;
							cur_row_q <= crow;
						end
					end
				end
				ST_UPD: begin
					cur_col_q <= col_next;
					if (scroll) begin
						cur_row_q <= erows_m1[RW-1:0];
						top_q     <= new_top;
						flag_q    <= '1;
						scol_q    <= '0;
						st_q      <= ST_SCRL;
					end else begin
						cur_row_q <= row_next;
						if (kind_q != K_READ_OUT) begin
							flag_q[prow_q] <= 1'b0;
						end
						st_q <= ST_IDLE;
					end
				end
				ST_SCRL: begin
					scol_q <= scol_q + CW'(1);
					if (scol_last) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command registers
	always_ff @(posedge clk) begin
		if (start) begin
			kind_q <= cmd.kind;
			code_q <= cmd.code;
			col_q  <= rd_col;
			prow_q <= rd_row;
		end
		if (st_q == ST_UPD) begin
			srow_q <= phys_row(erows_m1[RW-1:0], new_top);
		end
	end

	// Stores: registered reads on start, writes from the sequencer
	always_ff @(posedge clk) begin
		if (start) begin
			code_rd_q  <= code_mem[{rd_row, rd_col}];
			color_rd_q <= color_mem[{rd_row, rd_col}];
		end
		if (wr_en) begin
			code_mem[wr_addr]  <= wr_code;
			color_mem[wr_addr] <= wr_color;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dirty_rd_q <= dirty_mem[rd_row];
		end
		if ((st_q == ST_UPD) && (kind_q != K_READ_OUT)) begin
			dirty_mem[prow_q] <= row_new;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.cursor_col      = res_q.cursor_col;
	assign result.cursor_line     = res_q.cursor_line;
	assign result.did_scroll      = res_q.did_scroll;
	assign result.cell_code       = res_q.cell_code;
	assign result.cell_front      = res_q.cell_front;
	assign result.cell_back       = res_q.cell_back;
	assign result.cell_needs_draw = res_q.cell_needs_draw;

	// A result is loaded only into an empty or draining result register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || result.ready))
		else $error("result register overwritten");

	// No result leaves and no command is taken while the stores are being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLEAR) |-> (!out_valid_q && !cmd_ready))
		else $error("activity during clearing pass");

	// The scroll sweep stays inside the screen width
	a_scroll_col: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCRL) |-> ({1'b0, scol_q} < ecols))
		else $error("scroll sweep past last column");

	// After a put or newline update the cursor row is on screen
	a_row_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_UPD) && (kind_q == K_PUT || kind_q == K_NEWLINE))
		|=> ({1'b0, cur_row_q} < erows))
		else $error("cursor row off screen after put");

endmodule

`default_nettype wire

@@ sv/text_cell_console_cursor_scroll.sv @@
// A request passes the front register, the two-entry queue, the back part's command and
// store-read registers and the result register. The back part takes one request at a time:
// it reads, then updates the stores; a put that scrolls then blanks the on-screen columns of the new bottom row.
// Reset: asynchronous, active low; the cell stores are then cleared one entry per cycle,
// all 2**(clog2(MAX_ROWS)+clog2(MAX_COLUMNS)) entries (8192 by default), before requests execute.
// Up to three requests are buffered meanwhile; register writes are taken at any time.
`default_nettype none

module text_cell_console_cursor_scroll #(
	parameter int MAX_COLUMNS = tcc_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tcc_pkg::MAX_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	tcc_in_if.sink                           item,
	tcc_out_if.source                        result,
	input  logic                             cfg_we,
	input  logic [tcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tcc_pkg::*;

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols <= COLS_RESET;
			cfg_q.rows <= ROWS_RESET;
			cfg_q.text <= TEXT_RESET;
			cfg_q.back <= BACK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_COLUMNS: cfg_q.cols <= cfg_data[CFGCOL_W-1:0];
				CFG_ROWS:    cfg_q.rows <= cfg_data[CFGROW_W-1:0];
				CFG_TEXT:    cfg_q.text <= cfg_data[COLOR_W-1:0];
				CFG_BACK:    cfg_q.back <= cfg_data[COLOR_W-1:0];
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	tcc_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	tcc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	tcc_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.result    (result)
	);

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for text_cell_console_cursor_scroll: directed requests, then random phases.
// Checks every result against an in-bench console model or a fixed expected value; needs tcc_pkg
// and the tcc_in_if/tcc_out_if interfaces.

module testbench;
	import tcc_pkg::*;

	localparam int CYCLE_LIMIT = 700000;
	localparam int CELLS       = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 55;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_CYCLES = 400;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct {
		logic              op;
		logic [CODE_W-1:0] code;
		logic [COL_W-1:0]  rcol;
		logic [LINE_W-1:0] rline;
	} console_req_t;

	typedef struct {
		bit                    is_reg;
		cfg_idx_t              reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		console_req_t          req;
		bit                    has_want;
		res_t                  want;
	} drill_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tcc_in_if  item_ch();
	tcc_out_if result_ch();

	text_cell_console_cursor_scroll uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Console model state: screen contents, scroll offset, cursor, registers
	logic [CODE_W-1:0]   glyph_code  [CELLS];
	logic [COLOR_W-1:0]  glyph_front [CELLS];
	logic [COLOR_W-1:0]  glyph_back  [CELLS];
	bit                  glyph_dirty [CELLS];
	int                  top_row;
	int                  cur_c;
	int                  cur_r;
	logic [CFGCOL_W-1:0] cols_reg;
	logic [CFGROW_W-1:0] rows_reg;
	logic [COLOR_W-1:0]  text_reg;
	logic [COLOR_W-1:0]  back_reg;

	res_t console_replies [$];
	int   mismatches = 0;
	int   cycle_count = 0;

	function automatic int screen_cols();
		if (cols_reg == 0) return 1;
		if (cols_reg > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
		return int'(cols_reg);
	endfunction

	function automatic int screen_rows();
		if (rows_reg == 0) return 1;
		if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
		return int'(rows_reg);
	endfunction

	// Screen row maps to stored row through the scroll offset
	function automatic int cell_slot(int col, int row);
		return ((row + top_row) % MAX_ROWS_DEF) * MAX_COLUMNS_DEF + col;
	endfunction

	function automatic void model_init();
		for (int i = 0; i < CELLS; i++) begin
			glyph_code[i]  = SPACE_CODE;
			glyph_front[i] = DEFAULT_FRONT;
			glyph_back[i]  = DEFAULT_BACK;
			glyph_dirty[i] = 1'b1;
		end
		top_row  = 0;
		cur_c    = 0;
		cur_r    = 0;
		cols_reg = COLS_RESET;
		rows_reg = ROWS_RESET;
		text_reg = TEXT_RESET;
		back_reg = BACK_RESET;
	endfunction

	// Applies one request to the model and returns the result it produces
	function automatic res_t console_apply(input console_req_t r);
		res_t o;
		int   cols;
		int   rows;
		int   k;
		o = '0;
		if (r.op == OP_PUT) begin
			cols = screen_cols();
			rows = screen_rows();
			// screen may have shrunk under the cursor
			if (cur_c >= cols) cur_c = cols - 1;
			if (cur_r >= rows) cur_r = rows - 1;
			k = cell_slot(cur_c, cur_r);
			glyph_dirty[k] = 1'b1;
			if (r.code == NEWLINE_CODE) begin
				cur_c = 0;
				cur_r++;
			end else begin
				glyph_code[k]  = r.code;
				glyph_front[k] = text_reg;
				glyph_back[k]  = back_reg;
				cur_c++;
				if (cur_c >= cols) begin
					cur_c = 0;
					cur_r++;
				end
			end
			// scroll: blank the new bottom row, everything needs redraw
			if (cur_r >= rows) begin
				top_row = (top_row + 1) % MAX_ROWS_DEF;
				for (int i = 0; i < cols; i++) begin
					k = cell_slot(i, rows - 1);
					glyph_code[k]  = SPACE_CODE;
					glyph_front[k] = DEFAULT_FRONT;
					glyph_back[k]  = DEFAULT_BACK;
				end
				for (int i = 0; i < CELLS; i++) glyph_dirty[i] = 1'b1;
				cur_r = rows - 1;
				o.did_scroll = 1'b1;
			end
		end else if (r.rcol < MAX_COLUMNS_DEF && r.rline < MAX_ROWS_DEF) begin
			k = cell_slot(int'(r.rcol), int'(r.rline));
			o.cell_code       = glyph_code[k];
			o.cell_front      = glyph_front[k];
			o.cell_back       = glyph_back[k];
			o.cell_needs_draw = glyph_dirty[k];
			glyph_dirty[k]    = 1'b0;
		end
		o.cursor_col  = cur_c[COL_W-1:0];
		o.cursor_line = cur_r[LINE_W-1:0];
		return o;
	endfunction

	function automatic drill_row_t item_row(logic op, int code, int c, int l);
		drill_row_t r;
		r = '{reg_idx: CFG_COLUMNS, default: '0};
		r.req.op    = op;
		r.req.code  = CODE_W'(code);
		r.req.rcol  = COL_W'(c);
		r.req.rline = LINE_W'(l);
		return r;
	endfunction

	function automatic drill_row_t reg_row(cfg_idx_t idx, int val);
		drill_row_t r;
		r = '{reg_idx: CFG_COLUMNS, default: '0};
		r.is_reg  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = CFG_DATA_W'(val);
		return r;
	endfunction

	function automatic drill_row_t with_want(drill_row_t r, int cc, int cl, int code,
		int front, int back, bit dirty);
		r.has_want             = 1'b1;
		r.want                 = '0;
		r.want.cursor_col      = COL_W'(cc);
		r.want.cursor_line     = LINE_W'(cl);
		r.want.cell_code       = CODE_W'(code);
		r.want.cell_front      = COLOR_W'(front);
		r.want.cell_back       = COLOR_W'(back);
		r.want.cell_needs_draw = dirty;
		return r;
	endfunction

	function automatic console_req_t random_request();
		console_req_t r;
		int           pick;
		r.op    = OP_PUT;
		r.code  = CODE_W'($urandom_range(0, 1114111));
		r.rcol  = COL_W'($urandom_range(0, 127));
		r.rline = LINE_W'($urandom_range(0, 63));
		pick    = $urandom_range(0, 99);
		if (pick < 45) begin
			r.code = CODE_W'($urandom_range(32, 126));
		end else if (pick < 55) begin
			r.code = CODE_W'($urandom_range(0, 1114111));
		end else if (pick < 67) begin
			r.code = NEWLINE_CODE;
		end else begin
			r.op = OP_READ;
			// mostly cells on screen, sometimes anywhere in the store
			if ($urandom_range(0, 9) < 7) begin
				r.rcol  = COL_W'($urandom_range(0, screen_cols() - 1));
				r.rline = LINE_W'($urandom_range(0, screen_rows() - 1));
			end
		end
		return r;
	endfunction

	// Offer one request and hold it until accepted; prediction made at acceptance
	task automatic offer_request(input console_req_t r, input int gap, input bit has_want,
		input res_t want);
		res_t pred;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.op        <= r.op;
		item_ch.char_code <= r.code;
		item_ch.read_col  <= r.rcol;
		item_ch.read_line <= r.rline;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		pred = console_apply(r);
		console_replies.push_back(has_want ? want : pred);
	endtask

	task automatic drain_replies();
		item_ch.valid <= 1'b0;
		while (console_replies.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_COLUMNS: cols_reg = val[CFGCOL_W-1:0];
			CFG_ROWS:    rows_reg = val[CFGROW_W-1:0];
			CFG_TEXT:    text_reg = val;
			CFG_BACK:    back_reg = val;
		endcase
	endtask

	task automatic note_field(input string name, input logic [COLOR_W-1:0] want,
		input logic [COLOR_W-1:0] seen);
		if (want !== seen) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
			mismatches++;
		end
	endtask

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off, compare with oldest prediction
	initial begin : result_sink
		int   pause;
		int   taken;
		bit   steady;
		res_t seen;
		res_t want;
		result_ch.ready = 1'b0;
		taken  = 0;
		steady = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 40 == 0) steady = ($urandom_range(0, 3) == 0);
			pause = steady ? 0 : $urandom_range(0, 11);
			if (taken == HOLD_AT) pause = HOLD_CYCLES;
			if (pause > 0) begin
				result_ch.ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			taken++;
			seen.cursor_col      = result_ch.cursor_col;
			seen.cursor_line     = result_ch.cursor_line;
			seen.did_scroll      = result_ch.did_scroll;
			seen.cell_code       = result_ch.cell_code;
			seen.cell_front      = result_ch.cell_front;
			seen.cell_back       = result_ch.cell_back;
			seen.cell_needs_draw = result_ch.cell_needs_draw;
			if (console_replies.size() == 0) begin
				$display("%0t: result with nothing expected, actual %0h", $time, seen);
				mismatches++;
			end else begin
				want = console_replies.pop_front();
				note_field("cursor_col", COLOR_W'(want.cursor_col),
					COLOR_W'(seen.cursor_col));
				note_field("cursor_line", COLOR_W'(want.cursor_line),
					COLOR_W'(seen.cursor_line));
				note_field("did_scroll", COLOR_W'(want.did_scroll),
					COLOR_W'(seen.did_scroll));
				note_field("cell_code", COLOR_W'(want.cell_code),
					COLOR_W'(seen.cell_code));
				note_field("cell_front", want.cell_front, seen.cell_front);
				note_field("cell_back", want.cell_back, seen.cell_back);
				note_field("cell_needs_draw", COLOR_W'(want.cell_needs_draw),
					COLOR_W'(seen.cell_needs_draw));
			end
		end
	end

	// Request side
	initial begin : stimulus
		drill_row_t   drill [$];
		console_req_t r;
		int           p_cols [6];
		int           p_rows [6];
		bit           quiet;
		arst_n            = 1'b0;
		item_ch.valid     = 1'b0;
		item_ch.op        = OP_PUT;
		item_ch.char_code = '0;
		item_ch.read_col  = '0;
		item_ch.read_line = '0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_COLUMNS;
		cfg_data          = '0;
		p_cols = '{128, 8, 1, 255, 0, 20};
		p_rows = '{64, 4, 64, 127, 0, 5};
		model_init();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: fresh screen, dirty clear on read, extremes, 1x1 screen, oversize regs
		drill.push_back(with_want(item_row(OP_READ, 0, 0, 0), 0, 0, SPACE_CODE,
			DEFAULT_FRONT, DEFAULT_BACK, 1'b1));
		drill.push_back(with_want(item_row(OP_READ, 0, 0, 0), 0, 0, SPACE_CODE,
			DEFAULT_FRONT, DEFAULT_BACK, 1'b0));
		drill.push_back(with_want(item_row(OP_PUT, 65, 0, 0), 1, 0, 0, 0, 0, 1'b0));
		drill.push_back(with_want(item_row(OP_READ, 0, 0, 0), 1, 0, 65,
			TEXT_RESET, BACK_RESET, 1'b1));
		drill.push_back(with_want(item_row(OP_PUT, NEWLINE_CODE, 0, 0), 0, 1, 0, 0, 0, 1'b0));
		drill.push_back(with_want(item_row(OP_READ, 0, 127, 63), 0, 1, SPACE_CODE,
			DEFAULT_FRONT, DEFAULT_BACK, 1'b1));
		drill.push_back(with_want(item_row(OP_PUT, 'h10ffff, 127, 63), 1, 1, 0, 0, 0, 1'b0));
		drill.push_back(with_want(item_row(OP_PUT, 'h0f0000, 0, 0), 2, 1, 0, 0, 0, 1'b0));
		drill.push_back(with_want(item_row(OP_READ, 0, 1, 1), 2, 1, 'h0f0000,
			TEXT_RESET, BACK_RESET, 1'b1));
		drill.push_back(reg_row(CFG_TEXT, 'hffffff));
		drill.push_back(reg_row(CFG_BACK, 'h00ff00));
		drill.push_back(reg_row(CFG_COLUMNS, 0));
		drill.push_back(reg_row(CFG_ROWS, 0));
		drill.push_back(item_row(OP_PUT, 120, 0, 0));
		drill.push_back(item_row(OP_READ, 0, 0, 0));
		drill.push_back(item_row(OP_READ, 0, 0, 63));
		drill.push_back(item_row(OP_PUT, NEWLINE_CODE, 0, 0));
		drill.push_back(item_row(OP_READ, 0, 5, 1));
		drill.push_back(reg_row(CFG_COLUMNS, 255));
		drill.push_back(reg_row(CFG_ROWS, 127));
		drill.push_back(item_row(OP_PUT, 0, 0, 0));
		drill.push_back(item_row(OP_PUT, SPACE_CODE, 0, 0));
		drill.push_back(item_row(OP_PUT, NEWLINE_CODE, 0, 0));
		drill.push_back(item_row(OP_READ, 0, 1, 63));
		drill.push_back(item_row(OP_READ, 0, 127, 0));

		foreach (drill[i]) begin
			if (drill[i].is_reg) begin
				drain_replies();
				write_reg(drill[i].reg_idx, drill[i].reg_val);
			end else begin
				offer_request(drill[i].req, $urandom_range(0, 11), drill[i].has_want,
					drill[i].want);
			end
		end

		// Random phases, each under its own screen size and colors
		for (int p = 0; p < PHASES; p++) begin
			drain_replies();
			if (p < 6) begin
				write_reg(CFG_COLUMNS, CFG_DATA_W'(p_cols[p]));
				write_reg(CFG_ROWS, CFG_DATA_W'(p_rows[p]));
			end else begin
				write_reg(CFG_COLUMNS, CFG_DATA_W'($urandom_range(0, 255)));
				write_reg(CFG_ROWS, CFG_DATA_W'($urandom_range(0, 127)));
			end
			if (p == 0) begin
				write_reg(CFG_TEXT, 24'hffffff);
				write_reg(CFG_BACK, 24'h000000);
			end else if (p == 1) begin
				write_reg(CFG_TEXT, 24'h000000);
				write_reg(CFG_BACK, 24'hffffff);
			end else begin
				write_reg(CFG_TEXT, CFG_DATA_W'($urandom_range(0, 'hffffff)));
				write_reg(CFG_BACK, CFG_DATA_W'($urandom_range(0, 'hffffff)));
			end
			quiet = (p % 3 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = random_request();
				offer_request(r, quiet ? 0 : $urandom_range(0, 11), 1'b0, '0);
			end
		end

		drain_replies();
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
